### src/timed_priority_request_arbiter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the arbiter's modules
// ----------------------------------------------------------------------------
`ifndef TIMED_PRIORITY_REQUEST_ARBITER_TOP_DEFINES_SVH
`define TIMED_PRIORITY_REQUEST_ARBITER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define TPRA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define TPRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tpra_pkg.sv
// ----------------------------------------------------------------------------
// tpra_pkg
// Shared constants and controller/datapath interface types of the arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package tpra_pkg;

  // Slot table depth default
  localparam int NumSlotsDef = 8;

  // Field widths
  localparam int CmdW  = 2;
  localparam int KeyW  = 8;
  localparam int FaceW = 8;
  localparam int PrioW = 8;
  localparam int TimeW = 32;

  // Command codes
  localparam logic [CmdW-1:0] CMD_REQUEST = 2'd0;
  localparam logic [CmdW-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CmdW-1:0] CMD_TICK    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input beat, clear scan accumulators
    logic issue;    // read the next slot, advance the walk
    logic load;     // commit the item and load the result register
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_issue;  // current read address is the last slot
  } stat_t;

endpackage

`default_nettype wire

### src/tpra_ctrl.sv
// ----------------------------------------------------------------------------
// tpra_ctrl
// Sequencer of the arbiter: accepts a beat, walks the slot table, then
// commits the item and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_priority_request_arbiter_top_defines.svh"

module tpra_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output tpra_pkg::ctrl_t      ctl,
  input  wire tpra_pkg::stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Sequence one item through scan and commit; read slot zero in the accept cycle
  always_comb begin
    state_next  = state;
    ctl.capture = 1'b0;
    ctl.issue   = 1'b0;
    ctl.load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          ctl.issue   = 1'b1;
          if (stat.last_issue) begin
            state_next = S_DRAIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl.issue = 1'b1;
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          ctl.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    if (ctl.load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `TPRA_ASSERT_NEXT(a_accept_starts_scan, clk, rst, in_valid && !in_stall,
                    (state == S_SCAN) || (state == S_DRAIN),
                    "accepted beat did not start a scan")
  `TPRA_ASSERT_NEXT(a_commit_gives_beat, clk, rst, state == S_RESULT && out_free,
                    out_valid && state == S_IDLE, "commit did not present a result beat")

endmodule

`default_nettype wire

### src/tpra_dp.sv
// ----------------------------------------------------------------------------
// tpra_dp
// Datapath of the arbiter: slot memory, active bits, scan accumulators,
// shown face and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_priority_request_arbiter_top_defines.svh"

module tpra_dp #(
  parameter int NUM_SLOTS = tpra_pkg::NumSlotsDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tpra_pkg::ctrl_t            ctl,
  output tpra_pkg::stat_t                 stat,
  input  wire logic [tpra_pkg::CmdW-1:0]  cmd,
  input  wire logic [tpra_pkg::KeyW-1:0]  requester_key,
  input  wire logic [tpra_pkg::FaceW-1:0] face_code,
  input  wire logic [tpra_pkg::PrioW-1:0] prio,
  input  wire logic [tpra_pkg::TimeW-1:0] hold_ms,
  input  wire logic [tpra_pkg::TimeW-1:0] now_ms,
  output logic                            accepted,
  output logic [tpra_pkg::FaceW-1:0]      shown_face,
  output logic                            face_changed
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  typedef struct packed {
    logic [tpra_pkg::KeyW-1:0]  key;
    logic [tpra_pkg::FaceW-1:0] face;
    logic [tpra_pkg::PrioW-1:0] prio;
    logic [tpra_pkg::TimeW-1:0] start;
    logic [tpra_pkg::TimeW-1:0] hold;
  } slot_t;

  // Captured item
  logic [tpra_pkg::CmdW-1:0]  cmd_q;
  logic [tpra_pkg::KeyW-1:0]  key_q;
  logic [tpra_pkg::FaceW-1:0] face_q;
  logic [tpra_pkg::PrioW-1:0] prio_q;
  logic [tpra_pkg::TimeW-1:0] hold_q;
  logic [tpra_pkg::TimeW-1:0] now_q;

  // Slot table
  slot_t                slot_mem [NUM_SLOTS];
  slot_t                rd_slot;
  slot_t                wr_slot;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_idx;
  logic [NUM_SLOTS-1:0] active;

  // Walk
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] proc_idx;
  logic            proc_valid;

  // Scan accumulators
  logic                       match_found;
  logic [IdxW-1:0]            match_idx;
  logic                       free_found;
  logic [IdxW-1:0]            free_idx;
  logic                       best_found;
  logic [tpra_pkg::PrioW-1:0] best_prio;
  logic [tpra_pkg::FaceW-1:0] best_face;

  logic [tpra_pkg::FaceW-1:0] current_face;
  logic [tpra_pkg::FaceW-1:0] face_next;
  logic                       changed_next;
  logic                       accepted_next;

  // Per-slot evaluation
  logic                       proc_act;
  logic                       key_hit;
  logic [tpra_pkg::TimeW-1:0] elapsed;
  logic                       expired;
  logic                       is_req;
  logic                       is_rel;
  logic                       is_tick;

  assign is_req  = (cmd_q == tpra_pkg::CMD_REQUEST);
  assign is_rel  = (cmd_q == tpra_pkg::CMD_RELEASE);
  assign is_tick = (cmd_q == tpra_pkg::CMD_TICK);

  assign stat.last_issue = (rd_idx == LastIdx);

  assign proc_act = active[proc_idx];
  assign key_hit  = proc_act && (rd_slot.key == key_q);
  assign elapsed  = now_q - rd_slot.start;
  assign expired  = proc_act && (rd_slot.hold != '0) && (elapsed >= rd_slot.hold);

  // Resolve the commit of the finished item
  always_comb begin
    accepted_next = 1'b0;
    changed_next  = 1'b0;
    face_next     = current_face;
    if (is_req) begin
      accepted_next = match_found || free_found;
    end
    if (is_tick && best_found && (best_face != current_face)) begin
      face_next    = best_face;
      changed_next = 1'b1;
    end
  end

  assign wr_en           = ctl.load && is_req && accepted_next;
  assign wr_idx          = match_found ? match_idx : free_idx;
  assign wr_slot.key     = key_q;
  assign wr_slot.face    = face_q;
  assign wr_slot.prio    = prio_q;
  assign wr_slot.start   = now_q;
  assign wr_slot.hold    = hold_q;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q  <= cmd;
      key_q  <= requester_key;
      face_q <= face_code;
      prio_q <= prio;
      hold_q <= hold_ms;
      now_q  <= now_ms;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_idx] <= wr_slot;
    end
    if (ctl.issue) begin
      rd_slot <= slot_mem[rd_idx];
    end
  end

  // Advance the walk; wrap to slot zero after the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      proc_idx   <= '0;
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= ctl.issue;
      if (ctl.issue) begin
        rd_idx   <= stat.last_issue ? '0 : rd_idx + IdxW'(1);
        proc_idx <= rd_idx;
      end
    end
  end

  // Accumulate match, free slot and best candidate
  always_ff @(posedge clk) begin
    if (rst || ctl.capture) begin
      match_found <= 1'b0;
      match_idx   <= '0;
      free_found  <= 1'b0;
      free_idx    <= '0;
      best_found  <= 1'b0;
      best_prio   <= '0;
      best_face   <= '0;
    end else if (proc_valid) begin
      if (key_hit && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= proc_idx;
      end
      if (!proc_act && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= proc_idx;
      end
      if (is_tick && !expired && proc_act &&
          (!best_found || (rd_slot.prio > best_prio))) begin
        best_found <= 1'b1;
        best_prio  <= rd_slot.prio;
        best_face  <= rd_slot.face;
      end
    end
  end

  // Update active bits: expire on tick, set on request, drop on release
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (proc_valid) begin
      if (is_tick && expired) begin
        active[proc_idx] <= 1'b0;
      end
    end else if (ctl.load) begin
      if (wr_en) begin
        active[wr_idx] <= 1'b1;
      end else if (is_rel && match_found) begin
        active[match_idx] <= 1'b0;
      end
    end
  end

  // Shown face
  always_ff @(posedge clk) begin
    if (rst) begin
      current_face <= '0;
    end else if (ctl.load) begin
      current_face <= face_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      accepted     <= accepted_next;
      shown_face   <= face_next;
      face_changed <= changed_next;
    end
  end

  `TPRA_ASSERT_SAME(a_commit_after_scan, clk, rst, ctl.load, !proc_valid,
                    "commit overlaps slot processing")
  `TPRA_ASSERT_NEXT(a_shown_is_current, clk, rst, ctl.load, shown_face == current_face,
                    "result face differs from shown face")
  `TPRA_ASSERT_NEXT(a_change_only_tick, clk, rst, ctl.load && !is_tick, !face_changed,
                    "face change outside a tick")

endmodule

`default_nettype wire

### src/timed_priority_request_arbiter_top.sv
// ----------------------------------------------------------------------------
// timed_priority_request_arbiter_top
// Slot table of timed, prioritized face requests with tick-driven selection.
//
//   channel | direction | handshake           | fields
//   in      | sink      | in_valid / in_stall | cmd, requester_key, face_code,
//           |           |                     | prio, hold_ms, now_ms
//   out     | source    | out_valid/out_stall | accepted, shown_face,
//           |           |                     | face_changed
//
// The walk reads one slot per cycle through the slot memory's single read
// port, starting in the accept cycle, then passes a drain state and a commit
// state, where the commit waits for the output register to be free.
// Reset clears the active bits and the shown face; slot contents are not
// cleared and are only read behind an active bit.
// A stalled result beat is held in the output register; the next input beat
// is taken meanwhile, and its commit waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_priority_request_arbiter_top #(
  parameter int NUM_SLOTS = tpra_pkg::NumSlotsDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [tpra_pkg::CmdW-1:0]  cmd,
  input  wire logic [tpra_pkg::KeyW-1:0]  requester_key,
  input  wire logic [tpra_pkg::FaceW-1:0] face_code,
  input  wire logic [tpra_pkg::PrioW-1:0] prio,
  input  wire logic [tpra_pkg::TimeW-1:0] hold_ms,
  input  wire logic [tpra_pkg::TimeW-1:0] now_ms,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            accepted,
  output logic [tpra_pkg::FaceW-1:0]      shown_face,
  output logic                            face_changed
);

  tpra_pkg::ctrl_t ctl;
  tpra_pkg::stat_t stat;

  // Sequencer
  tpra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .stat      (stat)
  );

  // Slot table and selection
  tpra_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cmd           (cmd),
    .requester_key (requester_key),
    .face_code     (face_code),
    .prio          (prio),
    .hold_ms       (hold_ms),
    .now_ms        (now_ms),
    .accepted      (accepted),
    .shown_face    (shown_face),
    .face_changed  (face_changed)
  );

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: timed priority request arbiter regression
// Drives request, release, tick and unused commands into the arbiter through
// a valid/stall driver with random gaps. A slot-table predictor computes each
// result when its input beat is taken. The monitor stalls at random and
// checks every result beat against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int NSLOTS = tpra_pkg::NumSlotsDef;
  localparam logic [tpra_pkg::CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int STUCK_LIMIT = 3000;   // cycles with no beat on either side
  localparam int LONG_HOLD_AT = 500;   // result count that starts the long hold
  localparam int LONG_HOLD = 150;

  typedef struct {
    logic [tpra_pkg::CmdW-1:0]  cmd;
    logic [tpra_pkg::KeyW-1:0]  key;
    logic [tpra_pkg::FaceW-1:0] face;
    logic [tpra_pkg::PrioW-1:0] prio;
    logic [tpra_pkg::TimeW-1:0] hold;
    logic [tpra_pkg::TimeW-1:0] now;
    bit                         barrier;  // wait for every result before offering
    bit                         burst;    // no idling on either side
  } cmd_item_t;

  typedef struct {
    logic                       accepted;
    logic [tpra_pkg::FaceW-1:0] face;
    logic                       changed;
  } face_result_t;

  // DUT ports
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [tpra_pkg::CmdW-1:0]  cmd = tpra_pkg::CMD_TICK;
  logic [tpra_pkg::KeyW-1:0]  requester_key = '0;
  logic [tpra_pkg::FaceW-1:0] face_code = '0;
  logic [tpra_pkg::PrioW-1:0] prio = '0;
  logic [tpra_pkg::TimeW-1:0] hold_ms = '0;
  logic [tpra_pkg::TimeW-1:0] now_ms = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       accepted;
  logic [tpra_pkg::FaceW-1:0] shown_face;
  logic                       face_changed;

  // Predictor state: slot table and shown face
  bit                         arb_live [NSLOTS];
  logic [tpra_pkg::KeyW-1:0]  arb_key [NSLOTS];
  logic [tpra_pkg::FaceW-1:0] arb_face [NSLOTS];
  logic [tpra_pkg::PrioW-1:0] arb_prio [NSLOTS];
  logic [tpra_pkg::TimeW-1:0] arb_start [NSLOTS];
  logic [tpra_pkg::TimeW-1:0] arb_hold [NSLOTS];
  logic [tpra_pkg::FaceW-1:0] arb_shown = '0;

  cmd_item_t    cmd_backlog [$];
  face_result_t face_due [$];
  cmd_item_t    on_wire;
  logic [tpra_pkg::TimeW-1:0] wall_ms = 32'hFFFF_FE00;
  int  gap_left = 0;
  int  hold_left = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  stuck_cycles = 0;
  bit  burst_mode = 1'b0;

  timed_priority_request_arbiter_top #(
    .NUM_SLOTS(NSLOTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .requester_key(requester_key),
    .face_code    (face_code),
    .prio         (prio),
    .hold_ms      (hold_ms),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .shown_face   (shown_face),
    .face_changed (face_changed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one command to the slot table and return the result it produces
  function automatic face_result_t arbitrate(input cmd_item_t it);
    face_result_t               r;
    int                         hit;
    int                         i;
    bit                         found;
    logic [tpra_pkg::PrioW-1:0] best_prio;
    logic [tpra_pkg::FaceW-1:0] best_face;
    logic [tpra_pkg::TimeW-1:0] age;
    r.accepted = 1'b0;
    r.changed = 1'b0;
    hit = NSLOTS;
    found = 1'b0;
    best_prio = '0;
    best_face = '0;
    case (it.cmd)
      tpra_pkg::CMD_REQUEST: begin
        // refresh a matching slot, else take the lowest free one
        for (i = 0; i < NSLOTS; i++)
          if (hit == NSLOTS && arb_live[i] && arb_key[i] == it.key) hit = i;
        for (i = 0; i < NSLOTS; i++)
          if (hit == NSLOTS && !arb_live[i]) hit = i;
        if (hit < NSLOTS) begin
          arb_live[hit] = 1'b1;
          arb_key[hit] = it.key;
          arb_face[hit] = it.face;
          arb_prio[hit] = it.prio;
          arb_start[hit] = it.now;
          arb_hold[hit] = it.hold;
          r.accepted = 1'b1;
        end
      end
      tpra_pkg::CMD_RELEASE: begin
        for (i = 0; i < NSLOTS; i++)
          if (hit == NSLOTS && arb_live[i] && arb_key[i] == it.key) hit = i;
        if (hit < NSLOTS) arb_live[hit] = 1'b0;
      end
      tpra_pkg::CMD_TICK: begin
        // drop timed slots whose wrapping age reached their hold
        for (i = 0; i < NSLOTS; i++) begin
          age = it.now - arb_start[i];
          if (arb_live[i] && arb_hold[i] != '0 && age >= arb_hold[i]) arb_live[i] = 1'b0;
        end
        // highest priority wins, ties to the lowest index
        for (i = 0; i < NSLOTS; i++) begin
          if (arb_live[i] && (!found || arb_prio[i] > best_prio)) begin
            found = 1'b1;
            best_prio = arb_prio[i];
            best_face = arb_face[i];
          end
        end
        if (found && best_face != arb_shown) begin
          arb_shown = best_face;
          r.changed = 1'b1;
        end
      end
      default: ;
    endcase
    r.face = arb_shown;
    return r;
  endfunction

  task automatic queue_cmd(input logic [tpra_pkg::CmdW-1:0] c,
                           input logic [tpra_pkg::KeyW-1:0] k,
                           input logic [tpra_pkg::FaceW-1:0] f,
                           input logic [tpra_pkg::PrioW-1:0] p,
                           input logic [tpra_pkg::TimeW-1:0] h,
                           input logic [tpra_pkg::TimeW-1:0] n);
    cmd_item_t it;
    it = '{cmd: c, key: k, face: f, prio: p, hold: h, now: n, barrier: 1'b0, burst: 1'b0};
    cmd_backlog.push_back(it);
  endtask

  // Random command: small key, face and priority pools so slots collide,
  // fill up and tie; now follows a wrapping wall clock with rare jumps
  function automatic cmd_item_t random_cmd(input bit burst);
    cmd_item_t it;
    int        r;
    r = $urandom_range(0, 99);
    it.cmd = (r < 45) ? tpra_pkg::CMD_REQUEST :
             (r < 62) ? tpra_pkg::CMD_RELEASE :
             (r < 96) ? tpra_pkg::CMD_TICK : CMD_UNUSED;
    it.key = ($urandom_range(0, 99) < 85) ? tpra_pkg::KeyW'($urandom_range(0, 11)) :
             tpra_pkg::KeyW'($urandom);
    it.face = ($urandom_range(0, 99) < 70) ? tpra_pkg::FaceW'($urandom_range(0, 5)) :
              tpra_pkg::FaceW'($urandom);
    it.prio = ($urandom_range(0, 99) < 60) ? tpra_pkg::PrioW'($urandom_range(0, 3)) :
              tpra_pkg::PrioW'($urandom);
    r = $urandom_range(0, 99);
    it.hold = (r < 15) ? '0 : (r < 75) ? tpra_pkg::TimeW'($urandom_range(1, 40)) :
              (r < 90) ? tpra_pkg::TimeW'($urandom_range(41, 400)) :
              tpra_pkg::TimeW'($urandom);
    if ($urandom_range(0, 99) < 3) wall_ms = $urandom;
    else wall_ms = wall_ms + $urandom_range(0, 6);
    it.now = ($urandom_range(0, 99) < 5) ? tpra_pkg::TimeW'($urandom) : wall_ms;
    it.barrier = 1'b0;
    it.burst = burst;
    return it;
  endfunction

  // Stimulus plan, reset and end of run
  initial begin
    cmd_item_t it;
    int        i;
    // empty table, then the field extremes
    queue_cmd(tpra_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
    queue_cmd(tpra_pkg::CMD_REQUEST, 8'h00, 8'hFF, 8'h00, 32'h0, 32'h0);
    queue_cmd(tpra_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
    queue_cmd(tpra_pkg::CMD_REQUEST, 8'hFF, 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(tpra_pkg::CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'h0);
    // refresh in place, then a priority tie
    queue_cmd(tpra_pkg::CMD_REQUEST, 8'hFF, 8'h12, 8'h00, 32'd5, 32'd10);
    queue_cmd(tpra_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 32'h0, 32'd14);
    // expiry exactly at hold, unknown release, release, idle tick
    queue_cmd(tpra_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 32'h0, 32'd15);
    queue_cmd(tpra_pkg::CMD_RELEASE, 8'h55, 8'hAA, 8'h55, 32'hAAAA_5555, 32'h5555_AAAA);
    queue_cmd(tpra_pkg::CMD_RELEASE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
    queue_cmd(tpra_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 32'h0, 32'd20);
    // fill the table across the time wrap, then one request too many
    for (i = 1; i <= NSLOTS; i++)
      queue_cmd(tpra_pkg::CMD_REQUEST, tpra_pkg::KeyW'(i), tpra_pkg::FaceW'(8'h40 + i),
                tpra_pkg::PrioW'(i), tpra_pkg::TimeW'((i - 1) * 4), 32'hFFFF_FFF0);
    queue_cmd(tpra_pkg::CMD_REQUEST, tpra_pkg::KeyW'(NSLOTS + 1), 8'h77, 8'hFF, 32'd1,
              32'hFFFF_FFF0);
    queue_cmd(tpra_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0000_0008);
    queue_cmd(CMD_UNUSED, 8'h3C, 8'hC3, 8'h99, 32'h1234_5678, 32'h8765_4321);

    // random with idling, a drained pause, a burst, then random again
    for (i = 0; i < 900; i++) cmd_backlog.push_back(random_cmd(1'b0));
    it = random_cmd(1'b0);
    it.barrier = 1'b1;
    cmd_backlog.push_back(it);
    for (i = 0; i < 200; i++) cmd_backlog.push_back(random_cmd(1'b1));
    for (i = 0; i < 800; i++) cmd_backlog.push_back(random_cmd(1'b0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || in_valid || face_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Driver: predict on each taken beat, then offer the next after its gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) face_due.push_back(arbitrate(on_wire));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].barrier && face_due.size() != 0)) begin
          on_wire = cmd_backlog.pop_front();
          cmd <= on_wire.cmd;
          requester_key <= on_wire.key;
          face_code <= on_wire.face;
          prio <= on_wire.prio;
          hold_ms <= on_wire.hold;
          now_ms <= on_wire.now;
          in_valid <= 1'b1;
          burst_mode = on_wire.burst;
          gap_left = on_wire.burst ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s after %0d results: got %0h, want %0h",
             $realtime, what, results_seen, got, want);
    mismatches++;
  endtask

  // Monitor: check each result beat, then stall for a drawn number of cycles
  always @(posedge clk) begin
    face_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (face_due.size() == 0) begin
          flag_mismatch("unexpected beat", int'(shown_face), 0);
        end else begin
          want = face_due.pop_front();
          if (accepted !== want.accepted)
            flag_mismatch("accepted", int'(accepted), int'(want.accepted));
          if (shown_face !== want.face)
            flag_mismatch("shown_face", int'(shown_face), int'(want.face));
          if (face_changed !== want.changed)
            flag_mismatch("face_changed", int'(face_changed), int'(want.changed));
        end
        results_seen++;
        // hold off long once so the block backs up into its input
        if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD;
        else hold_left = burst_mode ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule

### sim.f
+incdir+src
src/tpra_pkg.sv
src/tpra_ctrl.sv
src/tpra_dp.sv
src/timed_priority_request_arbiter_top.sv
sim/tb_top.sv
